>>> rtl/core/rsp_pkg.sv
// rsp_pkg: shared types and constants of the receive slot pool
// no dependencies; imported by the slot pool top level and its checker
package rsp_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int PTR_W      = IDX_W + 1;

  localparam int ADDR_W     = 32;
  localparam int LEN_W      = 16;
  localparam int COOKIE_W   = 32;
  localparam int OUT_SLOT_W = 8;
  localparam int IN_SLOT_W  = 8;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(1600);

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_RELEASE = 2'd2,
    OP_DRAIN   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0]   address;
    logic [LEN_W-1:0]    length;
    logic [COOKIE_W-1:0] cookie;
  } slot_t;

endpackage

>>> rtl/core/rsp_ram.sv
// rsp_ram: generic single write port, single read port ram with registered read
// standalone; used for the free stack, the index fifo and the slot contents
module rsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/rx_slot_pool_with_fifo.sv
// rx_slot_pool_with_fifo: receive descriptor manager, free slot list plus index fifo
// depends on rsp_pkg and rsp_ram
//
// One request per cycle: enqueue, dequeue, release slot or drain begin. Each
// accepted request gives exactly one response, in the cycle after acceptance,
// in request order. Response data comes from the slot content memory, whose
// read is registered; the free list top and the fifo head are prefetched from
// their memories every cycle so back-to-back requests need no bubble. The
// input channel stalls only while a response is held by a stalled output.
// The free list is a stack (its linked form only ever pushes and pops at the
// head); its reset order 0, 1, 2 and so on is produced by a low-water mark instead
// of a clearing pass, so the block takes requests right out of reset. The
// max_frame_length register is written on the cfg channel, which is always
// ready; write it only while no request is in flight.
module rx_slot_pool_with_fifo
  import rsp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [LEN_W-1:0]      cfg_data_i,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            operation_i,
  input  logic [ADDR_W-1:0]     buffer_address_i,
  input  logic [LEN_W-1:0]      frame_length_i,
  input  logic [COOKIE_W-1:0]   cookie_i,
  input  logic [IN_SLOT_W-1:0]  slot_index_i,
  // response channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic                  notify_o,
  output logic [OUT_SLOT_W-1:0] out_slot_o,
  output logic [ADDR_W-1:0]     out_address_o,
  output logic [LEN_W-1:0]      out_length_o,
  output logic [COOKIE_W-1:0]   out_cookie_o,
  output logic                  reclaim_o
);

  // config register
  logic [LEN_W-1:0] max_len_q;

  // free stack: count of free slots and low-water mark of pushes
  logic [PTR_W-1:0] free_cnt_q, free_cnt_d;
  logic [PTR_W-1:0] low_q, low_d;
  logic [PTR_W-1:0] top_pos, new_top_pos;
  logic             stk_we;
  logic [IDX_W-1:0] stk_waddr, stk_raddr, stk_rdata;
  logic             stk_byp_q, stk_byp_d;
  logic [IDX_W-1:0] stk_byp_val_q;
  logic [IDX_W-1:0] free_top;

  // index fifo
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W-1:0] fifo_cnt;
  logic             fifo_full, fifo_empty;
  logic             fifo_we;
  logic [IDX_W-1:0] fifo_waddr, fifo_raddr, fifo_rdata;
  logic             fifo_byp_q, fifo_byp_d;
  logic [IDX_W-1:0] fifo_byp_val_q;
  logic [IDX_W-1:0] fifo_head;

  // slot contents and use flags
  logic                  slot_we, slot_re;
  logic [IDX_W-1:0]      slot_waddr, slot_raddr;
  slot_t                 slot_wdata, slot_rdata;
  logic [SLOT_COUNT-1:0] in_use_q, in_use_d;
  logic                  armed_q, armed_d;

  // request decode
  op_e              op;
  logic             accept;
  logic [IDX_W-1:0] sel_idx;
  logic             sel_ok;
  logic             too_long;
  logic             enq_ok, deq_ok, rel_ok;
  status_e          status_d;
  logic             notify_d;
  logic [IDX_W-1:0] slot_d;

  // response register
  logic             res_valid_q;
  status_e          res_status_q;
  logic             res_notify_q;
  logic [IDX_W-1:0] res_slot_q;
  logic             res_deq_q;
  logic             res_rcl_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = res_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign op          = op_e'(operation_i);

  // slot ids past the pool size are ignored by release
  assign sel_idx = IDX_W'(slot_index_i);
  assign sel_ok  = (32'(slot_index_i) < SLOT_COUNT);

  // free stack top: positions under the low-water mark still hold reset order
  assign top_pos = free_cnt_q - PTR_W'(1);
  always_comb begin
    if (top_pos < low_q) begin
      free_top = IDX_W'(SLOT_COUNT - 1) - top_pos[IDX_W-1:0];
    end else if (stk_byp_q) begin
      free_top = stk_byp_val_q;
    end else begin
      free_top = stk_rdata;
    end
  end

  assign fifo_head  = fifo_byp_q ? fifo_byp_val_q : fifo_rdata;
  assign fifo_cnt   = wr_q - rd_q;
  assign fifo_full  = (fifo_cnt == PTR_W'(SLOT_COUNT));
  assign fifo_empty = (wr_q == rd_q);
  assign too_long   = (frame_length_i > max_len_q);

  always_comb begin
    enq_ok   = 1'b0;
    deq_ok   = 1'b0;
    rel_ok   = 1'b0;
    status_d = ST_OK;
    notify_d = 1'b0;
    slot_d   = '0;
    armed_d  = armed_q;
    case (op)
      OP_ENQUEUE: begin
        if (too_long) begin
          status_d = ST_TOO_LONG;
        end else if (fifo_full || (free_cnt_q == '0)) begin
          status_d = ST_FULL;
        end else begin
          enq_ok   = accept;
          notify_d = !armed_q;
          slot_d   = free_top;
          armed_d  = accept ? 1'b1 : armed_q;
        end
      end
      OP_DEQUEUE: begin
        if (fifo_empty) begin
          status_d = ST_EMPTY;
        end else begin
          deq_ok = accept;
          slot_d = fifo_head;
        end
      end
      OP_RELEASE: begin
        rel_ok = accept && sel_ok && in_use_q[sel_idx];
      end
      OP_DRAIN: begin
        armed_d = accept ? 1'b0 : armed_q;
      end
      default: begin
        armed_d = armed_q;
      end
    endcase
  end

  // free stack update: enqueue pops, release pushes
  always_comb begin
    free_cnt_d = free_cnt_q;
    low_d      = low_q;
    stk_we     = 1'b0;
    stk_waddr  = free_cnt_q[IDX_W-1:0];
    if (enq_ok) begin
      free_cnt_d = free_cnt_q - PTR_W'(1);
    end else if (rel_ok) begin
      free_cnt_d = free_cnt_q + PTR_W'(1);
      stk_we     = 1'b1;
      if (free_cnt_q < low_q) begin
        low_d = free_cnt_q;
      end
    end
  end

  // always prefetch the next top; bypass when it is written on the same edge
  assign new_top_pos = free_cnt_d - PTR_W'(1);
  assign stk_raddr   = new_top_pos[IDX_W-1:0];
  assign stk_byp_d   = stk_we && (stk_waddr == stk_raddr);

  // index fifo: push on enqueue, pop on dequeue, head prefetched the same way
  assign fifo_we    = enq_ok;
  assign fifo_waddr = wr_q[IDX_W-1:0];
  assign wr_d       = enq_ok ? (wr_q + PTR_W'(1)) : wr_q;
  assign rd_d       = deq_ok ? (rd_q + PTR_W'(1)) : rd_q;
  assign fifo_raddr = rd_d[IDX_W-1:0];
  assign fifo_byp_d = fifo_we && (fifo_waddr == fifo_raddr);

  // slot contents: enqueue stores, release clears; dequeue and release read
  assign slot_we    = enq_ok || rel_ok;
  assign slot_waddr = enq_ok ? free_top : sel_idx;
  always_comb begin
    slot_wdata = '0;
    if (enq_ok) begin
      slot_wdata.address = buffer_address_i;
      slot_wdata.length  = frame_length_i;
      slot_wdata.cookie  = cookie_i;
    end
  end
  assign slot_re    = deq_ok || rel_ok;
  assign slot_raddr = deq_ok ? fifo_head : sel_idx;

  always_comb begin
    in_use_d = in_use_q;
    if (enq_ok) begin
      in_use_d[free_top] = 1'b1;
    end
    if (rel_ok) begin
      in_use_d[sel_idx] = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= MAX_LEN_RESET;
      free_cnt_q  <= PTR_W'(SLOT_COUNT);
      low_q       <= PTR_W'(SLOT_COUNT);
      stk_byp_q   <= 1'b0;
      wr_q        <= '0;
      rd_q        <= '0;
      fifo_byp_q  <= 1'b0;
      in_use_q    <= '0;
      armed_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_data_i;
      end
      free_cnt_q <= free_cnt_d;
      low_q      <= low_d;
      stk_byp_q  <= stk_byp_d;
      wr_q       <= wr_d;
      rd_q       <= rd_d;
      fifo_byp_q <= fifo_byp_d;
      in_use_q   <= in_use_d;
      armed_q    <= armed_d;
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // bypass values and response payload
  always_ff @(posedge clk_i) begin
    stk_byp_val_q  <= sel_idx;
    fifo_byp_val_q <= free_top;
    if (accept) begin
      res_status_q <= status_d;
      res_notify_q <= notify_d;
      res_slot_q   <= slot_d;
      res_deq_q    <= deq_ok;
      res_rcl_q    <= rel_ok;
    end
  end

  rsp_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOT_COUNT)
  ) u_free_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (sel_idx),
    .re_i    (1'b1),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  rsp_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOT_COUNT)
  ) u_index_fifo (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_waddr),
    .wdata_i (free_top),
    .re_i    (1'b1),
    .raddr_i (fifo_raddr),
    .rdata_o (fifo_rdata)
  );

  rsp_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOT_COUNT)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // response: slot data only for a dequeue, cookie also for a reclaim
  assign out_valid_o   = res_valid_q;
  assign status_o      = res_status_q;
  assign notify_o      = res_notify_q;
  assign out_slot_o    = OUT_SLOT_W'(res_slot_q);
  assign out_address_o = res_deq_q ? slot_rdata.address : '0;
  assign out_length_o  = res_deq_q ? slot_rdata.length : '0;
  assign out_cookie_o  = (res_deq_q || res_rcl_q) ? slot_rdata.cookie : '0;
  assign reclaim_o     = res_rcl_q;

endmodule

>>> rtl/core/rsp_chk.sv
// rsp_chk: port-level checker for the receive slot pool, bound to the top level
// depends on rsp_pkg
module rsp_chk
  import rsp_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [LEN_W-1:0]      cfg_data_i,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [1:0]            operation_i,
  input logic [ADDR_W-1:0]     buffer_address_i,
  input logic [LEN_W-1:0]      frame_length_i,
  input logic [COOKIE_W-1:0]   cookie_i,
  input logic [IN_SLOT_W-1:0]  slot_index_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [1:0]            status_o,
  input logic                  notify_o,
  input logic [OUT_SLOT_W-1:0] out_slot_o,
  input logic [ADDR_W-1:0]     out_address_o,
  input logic [LEN_W-1:0]      out_length_o,
  input logic [COOKIE_W-1:0]   out_cookie_o,
  input logic                  reclaim_o
);

  // a stalled response stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("response dropped while stalled");

  // requests are held back only by a pending response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("request stalled with no pending response");

  // every accepted request gives a response on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("missing response after accepted request");

  // a reclaim is a successful release with no notify, address or length reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reclaim_o |->
      status_o == ST_OK && !notify_o && out_address_o == '0 && out_length_o == '0)
    else $error("reclaim response carries extra fields");

  // drops and empty dequeues report no slot data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_TOO_LONG || status_o == ST_FULL ||
                    status_o == ST_EMPTY) |->
      !notify_o && !reclaim_o && out_slot_o == '0 && out_cookie_o == '0)
    else $error("failed request reports slot data");

endmodule

bind rx_slot_pool_with_fifo rsp_chk u_rsp_chk (.*);

>>> test/rx_slot_pool_with_fifo_test.sv
`timescale 1ns / 100ps
// rx_slot_pool_with_fifo_test: self-checking bench for the receive slot pool
// depends on rsp_pkg and rx_slot_pool_with_fifo; drives requests, predicts each response
module rx_slot_pool_with_fifo_test;
  import rsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    op_e                  op;
    logic [ADDR_W-1:0]    address;
    logic [LEN_W-1:0]     length;
    logic [COOKIE_W-1:0]  cookie;
    logic [IN_SLOT_W-1:0] slot;
  } pool_req_t;

  typedef struct {
    status_e               status;
    logic                  notify;
    logic [OUT_SLOT_W-1:0] slot;
    logic [ADDR_W-1:0]     address;
    logic [LEN_W-1:0]      length;
    logic [COOKIE_W-1:0]   cookie;
    logic                  reclaim;
  } pool_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data = '0;

  logic      in_valid = 1'b0;
  logic      in_stall;
  pool_req_t drv_req = '{OP_ENQUEUE, '0, '0, '0, '0};

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            status;
  logic                  notify;
  logic [OUT_SLOT_W-1:0] out_slot;
  logic [ADDR_W-1:0]     out_address;
  logic [LEN_W-1:0]      out_length;
  logic [COOKIE_W-1:0]   out_cookie;
  logic                  reclaim;

  // request stream and predicted responses, oldest first
  pool_req_t  pending_reqs[$];
  pool_resp_t expected_resps[$];

  // percent of cycles in which the sender holds back, and apart from that, in which the receiver stalls
  int   idle_pct = 26;
  logic req_taken = 1'b0;
  int   mismatches = 0;

  // predicted pool state
  logic [LEN_W-1:0]    max_len_m;
  logic [PTR_W-1:0]    pool_next [SLOT_COUNT];
  logic [PTR_W-1:0]    pool_head;
  logic [IDX_W-1:0]    queued_slot [SLOT_COUNT];
  logic [PTR_W-1:0]    q_wr;
  logic [PTR_W-1:0]    q_rd;
  logic                notify_armed;
  logic                slot_busy [SLOT_COUNT];
  logic [ADDR_W-1:0]   held_addr [SLOT_COUNT];
  logic [LEN_W-1:0]    held_len [SLOT_COUNT];
  logic [COOKIE_W-1:0] held_cookie [SLOT_COUNT];

  always #5 clk = ~clk;

  rx_slot_pool_with_fifo DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .operation_i      (drv_req.op),
    .buffer_address_i (drv_req.address),
    .frame_length_i   (drv_req.length),
    .cookie_i         (drv_req.cookie),
    .slot_index_i     (drv_req.slot),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .notify_o         (notify),
    .out_slot_o       (out_slot),
    .out_address_o    (out_address),
    .out_length_o     (out_length),
    .out_cookie_o     (out_cookie),
    .reclaim_o        (reclaim)
  );

  // apply one request to the predicted pool and return its response
  function automatic pool_resp_t apply_to_pool(input pool_req_t r);
    pool_resp_t       o;
    logic [IDX_W-1:0] idx;
    logic [PTR_W-1:0] depth;
    o.status  = ST_OK;
    o.notify  = 1'b0;
    o.slot    = '0;
    o.address = '0;
    o.length  = '0;
    o.cookie  = '0;
    o.reclaim = 1'b0;
    depth = q_wr - q_rd;
    case (r.op)
      OP_ENQUEUE: begin
        // length is checked ahead of any full condition
        if (r.length > max_len_m) begin
          o.status = ST_TOO_LONG;
        end else if (int'(depth) >= SLOT_COUNT || int'(pool_head) >= SLOT_COUNT) begin
          o.status = ST_FULL;
        end else begin
          idx = pool_head[IDX_W-1:0];
          pool_head = pool_next[idx];
          held_addr[idx] = r.address;
          held_len[idx] = r.length;
          held_cookie[idx] = r.cookie;
          slot_busy[idx] = 1'b1;
          queued_slot[q_wr[IDX_W-1:0]] = idx;
          q_wr = q_wr + 1'b1;
          if (!notify_armed) begin
            notify_armed = 1'b1;
            o.notify = 1'b1;
          end
          o.slot = OUT_SLOT_W'(idx);
        end
      end
      OP_DEQUEUE: begin
        if (depth == '0) begin
          o.status = ST_EMPTY;
        end else begin
          // a slot released while queued reports its cleared contents
          idx = queued_slot[q_rd[IDX_W-1:0]];
          q_rd = q_rd + 1'b1;
          o.slot = OUT_SLOT_W'(idx);
          o.address = held_addr[idx];
          o.length = held_len[idx];
          o.cookie = held_cookie[idx];
        end
      end
      OP_RELEASE: begin
        // a slot not in use is left alone, so a double free does nothing
        if (int'(r.slot) < SLOT_COUNT && slot_busy[r.slot]) begin
          idx = IDX_W'(r.slot);
          o.cookie = held_cookie[idx];
          o.reclaim = 1'b1;
          slot_busy[idx] = 1'b0;
          held_addr[idx] = '0;
          held_len[idx] = '0;
          held_cookie[idx] = '0;
          pool_next[idx] = pool_head;
          pool_head = PTR_W'(idx);
        end
      end
      default: begin
        notify_armed = 1'b0;
      end
    endcase
    return o;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void queue_req(input op_e op, input logic [ADDR_W-1:0] address,
                                    input logic [LEN_W-1:0] length,
                                    input logic [COOKIE_W-1:0] cookie,
                                    input logic [IN_SLOT_W-1:0] slot);
    pending_reqs.push_back('{op, address, length, cookie, slot});
  endfunction

  // random request; weights in percent, drain takes what is left
  function automatic pool_req_t random_req(input int w_enq, input int w_deq, input int w_rel,
                                           input int wild_pct, input int slot_hi);
    pool_req_t r;
    int        pick;
    int        near;
    r.address = $urandom;
    r.cookie = $urandom;
    r.slot = ($urandom_range(4) == 0) ? IN_SLOT_W'($urandom)
                                      : IN_SLOT_W'($urandom_range(slot_hi));
    pick = $urandom_range(99);
    if (pick < w_enq) r.op = OP_ENQUEUE;
    else if (pick < w_enq + w_deq) r.op = OP_DEQUEUE;
    else if (pick < w_enq + w_deq + w_rel) r.op = OP_RELEASE;
    else r.op = OP_DRAIN;
    pick = $urandom_range(99);
    if (pick < wild_pct) begin
      r.length = LEN_W'($urandom);
    end else if (pick < wild_pct + 10) begin
      // just below, at and just above the length limit
      near = int'(max_len_m) + int'($urandom_range(2)) - 1;
      if (near < 0) near = 0;
      if (near > 65535) near = 65535;
      r.length = LEN_W'(near);
    end else begin
      r.length = LEN_W'($urandom_range(int'(max_len_m)));
    end
    return r;
  endfunction

  // wait until every request is in and answered
  task automatic settle_pool();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_resps.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_max_len(input logic [LEN_W-1:0] value);
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    max_len_m = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] max_len, input int count, input int idle,
                           input int w_enq, input int w_deq, input int w_rel,
                           input int wild_pct, input int slot_hi);
    write_max_len(max_len);
    idle_pct = idle;
    repeat (count) pending_reqs.push_back(random_req(w_enq, w_deq, w_rel, wild_pct, slot_hi));
    settle_pool();
  endtask

  // request driver: holds a request until taken, then moves on or idles
  always @(negedge clk) begin : drive_requests
    pool_req_t nxt;
    if (rst_n) begin
      if (!in_valid || req_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_reqs.pop_front();
          drv_req <= nxt;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // response monitor: check what leaves first, then predict what enters
  always @(posedge clk) begin : check_responses
    pool_resp_t want;
    if (out_valid && !out_stall) begin
      if (expected_resps.size() == 0) begin
        $error("response with no request outstanding: status %0d slot %0h", status, out_slot);
        mismatches++;
      end else begin
        want = expected_resps.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("notify", 32'(want.notify), 32'(notify));
        check_field("out_slot", 32'(want.slot), 32'(out_slot));
        check_field("out_address", want.address, out_address);
        check_field("out_length", 32'(want.length), 32'(out_length));
        check_field("out_cookie", want.cookie, out_cookie);
        check_field("reclaim", 32'(want.reclaim), 32'(reclaim));
      end
    end
    if (in_valid && !in_stall) begin
      expected_resps.push_back(apply_to_pool(drv_req));
    end
    req_taken <= in_valid && !in_stall;
  end

  // watchdog: too many cycles in a row with no handshake on any channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    max_len_m = MAX_LEN_RESET;
    pool_head = '0;
    q_wr = '0;
    q_rd = '0;
    notify_armed = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      pool_next[i] = PTR_W'(i + 1);
      queued_slot[i] = '0;
      slot_busy[i] = 1'b0;
      held_addr[i] = '0;
      held_len[i] = '0;
      held_cookie[i] = '0;
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed part at the reset length limit
    queue_req(OP_DEQUEUE, '0, '0, '0, '0);                    // empty fifo
    queue_req(OP_RELEASE, '0, '0, '0, 8'd0);                  // slot never used
    queue_req(OP_RELEASE, '1, '1, '1, 8'hff);                 // top slot, never used
    queue_req(OP_ENQUEUE, '0, '0, '0, '0);                    // zero frame, arms notify
    queue_req(OP_ENQUEUE, '1, 16'd1600, '1, '1);              // exactly at the limit
    queue_req(OP_ENQUEUE, 32'h1234_5678, 16'd1601, 32'h1, '0); // one byte too long
    queue_req(OP_ENQUEUE, '1, '1, '1, '1);                    // longest length
    queue_req(OP_DRAIN, '0, '0, '0, '0);
    queue_req(OP_ENQUEUE, 32'ha5a5_5a5a, 16'd64, 32'h5a5a_a5a5, '0);
    queue_req(OP_DEQUEUE, '1, '1, '1, '1);
    queue_req(OP_RELEASE, '0, '0, '0, 8'd0);                  // reclaim after dequeue
    queue_req(OP_RELEASE, '0, '0, '0, 8'd0);                  // double free
    queue_req(OP_RELEASE, '0, '0, '0, 8'd1);                  // freed while still queued
    queue_req(OP_DEQUEUE, '0, '0, '0, '0);                    // reports cleared slot
    queue_req(OP_DEQUEUE, '0, '0, '0, '0);
    queue_req(OP_DEQUEUE, '0, '0, '0, '0);                    // empty again
    queue_req(OP_ENQUEUE, 32'hdead_beef, 16'd1500, 32'hcafe_f00d, '0); // reuses freed slot
    queue_req(OP_RELEASE, '0, '0, '0, 8'd2);
    queue_req(OP_DRAIN, '0, '0, '0, '0);
    queue_req(OP_DRAIN, '0, '0, '0, '0);
    queue_req(OP_ENQUEUE, 32'h0000_0001, 16'd1, 32'h8000_0000, '0);
    settle_pool();

    // zero limit: only empty frames get in
    run_phase(16'd0, 40, 26, 50, 20, 20, 30, 15);
    // widest limit, general mix
    run_phase(16'hffff, 180, 26, 40, 25, 25, 30, 31);
    // back to back enqueues with no idling until fifo and free list run out
    run_phase(LEN_W'($urandom_range(3000, 1000)), 300, 0, 97, 0, 0, 4, 0);
    // drain the full pool, releasing slots all over the index range
    run_phase(16'd1600, 200, 26, 25, 35, 35, 10, 255);

    repeat (10) @(negedge clk);
    if (expected_resps.size() != 0) begin
      $error("%0d responses never arrived", expected_resps.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
